FILE: rtl/core/hpt_pkg.sv
// shared types and constants of the hall pulse period tachometer
`default_nettype none

package hpt_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CHAN_W  = 2;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LOW_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STOP_TIMEOUT = 1'd1;

	localparam logic [CFG_W-1:0] MIN_LOW_WIDTH_RST    = 32'd5000;
	localparam logic [CFG_W-1:0] MIN_STOP_TIMEOUT_RST = 32'd2000000;

	localparam logic OP_EDGE  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		OUTC_QUERY    = 3'd0,
		OUTC_ARMED    = 3'd1,
		OUTC_IGNORED  = 3'd2,
		OUTC_GLITCH   = 3'd3,
		OUTC_ACCEPTED = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		RUN_WAITING = 2'd0,
		RUN_RUNNING = 2'd1,
		RUN_STOPPED = 2'd2
	} run_status_t;

	// one memory word per channel
	typedef struct packed {
		logic [TIME_W-1:0] low_start;
		logic              low_armed;
		logic [TIME_W-1:0] last_pulse;
		logic              last_valid;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] pulses;
		logic [TIME_W-1:0] glitches;
	} chan_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/hpt_ifs.sv
// item and result channel interfaces
`default_nettype none

interface hpt_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [1:0]  channel;
	logic        level;
	logic [31:0] time_us;

	modport source (output valid, output operation, output channel, output level,
		output time_us, input ready);
	modport sink (input valid, input operation, input channel, input level,
		input time_us, output ready);
endinterface

interface hpt_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  edge_outcome;
	logic [1:0]  run_status;
	logic [31:0] period_us;
	logic [31:0] pulse_total;
	logic [31:0] glitch_total;

	modport source (output valid, output edge_outcome, output run_status,
		output period_us, output pulse_total, output glitch_total, input ready);
	modport sink (input valid, input edge_outcome, input run_status,
		input period_us, input pulse_total, input glitch_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hpt_state_mem.sv
// per-channel state memory, registered read, entry valid bits
`default_nettype none

module hpt_state_mem #(
	parameter int unsigned CHANNELS = 4,
	parameter int unsigned AW       = 2
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       rd_en,
	input  wire [AW-1:0]              rd_addr,
	output hpt_pkg::chan_state_t      rd_data,
	input  wire                       wr_en,
	input  wire [AW-1:0]              wr_addr,
	input  hpt_pkg::chan_state_t      wr_data
);

	hpt_pkg::chan_state_t mem [CHANNELS];
	hpt_pkg::chan_state_t rd_data_q;
	logic [CHANNELS-1:0]  vld_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// an entry never written reads as the cleared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/hpt_update.sv
// edge event update of one channel's state
`default_nettype none

module hpt_update (
	input  hpt_pkg::chan_state_t cur,
	input  wire                  operation,
	input  wire                  level,
	input  wire [31:0]           now,
	input  wire [31:0]           min_low_width,
	output hpt_pkg::chan_state_t nxt,
	output hpt_pkg::outcome_t    outcome
);

	logic [31:0] low_time;
	logic [31:0] new_period;

	assign low_time   = now - cur.low_start;
	assign new_period = cur.low_start - cur.last_pulse;

	always_comb begin
		nxt     = cur;
		outcome = hpt_pkg::OUTC_QUERY;
		if (operation == hpt_pkg::OP_EDGE) begin
			if (!level) begin
				nxt.low_start = now;
				nxt.low_armed = 1'b1;
				outcome       = hpt_pkg::OUTC_ARMED;
			end else if (!cur.low_armed) begin
				outcome = hpt_pkg::OUTC_IGNORED;
			end else begin
				nxt.low_armed = 1'b0;
				if (low_time < min_low_width) begin
					nxt.glitches = cur.glitches + 32'd1;
					outcome      = hpt_pkg::OUTC_GLITCH;
				end else begin
					if (cur.last_valid) begin
						nxt.period = new_period;
					end
					nxt.last_pulse = cur.low_start;
					nxt.last_valid = 1'b1;
					nxt.pulses     = cur.pulses + 32'd1;
					outcome        = hpt_pkg::OUTC_ACCEPTED;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hpt_status.sv
// waiting / running / stopped decision with adaptive timeout
`default_nettype none

module hpt_status (
	input  wire [31:0]            period,
	input  wire [31:0]            last_pulse,
	input  wire [31:0]            now,
	input  wire [31:0]            min_stop_timeout,
	output hpt_pkg::run_status_t  status
);

	logic [33:0] scaled;
	logic [31:0] timeout;
	logic [31:0] since;

	// three periods as p + 2p
	assign scaled = {2'b00, period} + {1'b0, period, 1'b0};
	assign since  = now - last_pulse;

	always_comb begin
		if (scaled > {2'b00, min_stop_timeout}) begin
			timeout = (scaled[33:32] != 2'b00) ? '1 : scaled[31:0];
		end else begin
			timeout = min_stop_timeout;
		end
		if (period == '0) begin
			status = hpt_pkg::RUN_WAITING;
		end else if (since > timeout) begin
			status = hpt_pkg::RUN_STOPPED;
		end else begin
			status = hpt_pkg::RUN_RUNNING;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hall_pulse_period_tachometer.sv
// top level of the multi-channel hall pulse period tachometer
`default_nettype none

// Multi-channel hall tachometer. Each item transfer is an edge event or a
// status query for one channel; each produces exactly one result transfer.
// One item is taken per clock cycle while no result waits to be taken. The
// edge that takes an item also clocks the registered read of the per-channel
// state memory. In the cycle after that edge the edge update is applied. The
// next advancing edge writes the entry back and loads the result register,
// which then drives the result. The stop/run status is worked out from the
// updated state held in the result register. Back-to-back items on the same
// channel are served by forwarding the entry written in the previous cycle.
// The whole pipeline holds while a result waits to be taken. Configuration
// writes (index 0 minimum low width, index 1 minimum stop timeout, both in
// microseconds) are expected only while no item is in flight.

module hall_pulse_period_tachometer #(
	parameter int unsigned CHANNELS = 4
) (
	input  wire                clk,
	input  wire                arst_n,
	hpt_item_if.sink           item,
	hpt_result_if.source       result,
	input  wire                cfg_we,
	input  wire [0:0]          cfg_index,
	input  wire [31:0]         cfg_data
);

	localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// configuration registers
	logic [31:0] min_low_width_q;
	logic [31:0] min_stop_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_low_width_q    <= hpt_pkg::MIN_LOW_WIDTH_RST;
			min_stop_timeout_q <= hpt_pkg::MIN_STOP_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hpt_pkg::REG_MIN_LOW_WIDTH:    min_low_width_q    <= cfg_data;
				hpt_pkg::REG_MIN_STOP_TIMEOUT: min_stop_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the result register is free or being drained
	logic adv;
	logic in_xfer;
	logic in_range;

	assign adv        = !result.valid || result.ready;
	assign item.ready = adv;
	assign in_xfer    = item.valid && adv;
	assign in_range   = 32'(item.channel) < 32'(CHANNELS);

	// stage 1: memory read in flight
	logic        v_s1;
	logic        op_s1;
	logic [1:0]  ch_s1;
	logic        lvl_s1;
	logic [31:0] now_s1;
	logic        inr_s1;

	// stage 2: result register
	logic                  v_s2;
	hpt_pkg::chan_state_t  st_s2;
	hpt_pkg::outcome_t     outc_s2;
	logic [31:0]           now_s2;
	logic                  inr_s2;

	// last write-back, for same-channel forwarding
	logic                  wb_v_q;
	logic [1:0]            wb_ch_q;
	hpt_pkg::chan_state_t  wb_data_q;

	hpt_pkg::chan_state_t  mem_rd;
	hpt_pkg::chan_state_t  cur;
	hpt_pkg::chan_state_t  nxt;
	hpt_pkg::outcome_t     outc;
	hpt_pkg::run_status_t  status;
	logic                  wr_en;

	assign wr_en = adv && v_s1 && inr_s1;

	hpt_state_mem #(
		.CHANNELS (CHANNELS),
		.AW       (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer && in_range),
		.rd_addr (AW'(item.channel)),
		.rd_data (mem_rd),
		.wr_en   (wr_en),
		.wr_addr (AW'(ch_s1)),
		.wr_data (nxt)
	);

	// the entry written at the read edge is newer than the read data
	assign cur = (wb_v_q && wb_ch_q == ch_s1) ? wb_data_q : mem_rd;

	hpt_update u_update (
		.cur           (cur),
		.operation     (op_s1),
		.level         (lvl_s1),
		.now           (now_s1),
		.min_low_width (min_low_width_q),
		.nxt           (nxt),
		.outcome       (outc)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			wb_v_q <= 1'b0;
		end else if (adv) begin
			v_s1   <= item.valid;
			v_s2   <= v_s1;
			wb_v_q <= v_s1 && inr_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1     <= item.operation;
			ch_s1     <= item.channel;
			lvl_s1    <= item.level;
			now_s1    <= item.time_us;
			inr_s1    <= in_range;
			st_s2     <= nxt;
			now_s2    <= now_s1;
			inr_s2    <= inr_s1;
			wb_ch_q   <= ch_s1;
			wb_data_q <= nxt;
			// a channel outside the array leaves the state alone
			if (inr_s1) begin
				outc_s2 <= outc;
			end else if (op_s1 == hpt_pkg::OP_QUERY) begin
				outc_s2 <= hpt_pkg::OUTC_QUERY;
			end else begin
				outc_s2 <= hpt_pkg::OUTC_IGNORED;
			end
		end
	end

	hpt_status u_status (
		.period           (st_s2.period),
		.last_pulse       (st_s2.last_pulse),
		.now              (now_s2),
		.min_stop_timeout (min_stop_timeout_q),
		.status           (status)
	);

	// result fields; status, period and totals are zero for a channel outside the array
	assign result.valid        = v_s2;
	assign result.edge_outcome = outc_s2;
	assign result.run_status   = inr_s2 ? status : hpt_pkg::RUN_WAITING;
	assign result.period_us    = inr_s2 ? st_s2.period : '0;
	assign result.pulse_total  = inr_s2 ? st_s2.pulses : '0;
	assign result.glitch_total = inr_s2 ? st_s2.glitches : '0;

endmodule

`default_nettype wire
